// File: rtl/core/stu_pkg.sv
// Shared types, token codes and keyword table for the source tokenizer.
`timescale 1ns / 1ps
package stu_pkg;

	localparam int MAX_KEYWORD_LEN_DEF = 6;
	localparam int POSITION_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF     = 4;
	localparam int KW_COUNT            = 13;
	localparam int KW_MAX_CHARS        = 6;

	localparam logic [5:0] K_IDENT    = 6'd13;
	localparam logic [5:0] K_INTLIT   = 6'd14;
	localparam logic [5:0] K_FLOATLIT = 6'd15;
	localparam logic [5:0] K_STRLIT   = 6'd16;
	localparam logic [5:0] K_PLUS     = 6'd17;
	localparam logic [5:0] K_MINUS    = 6'd18;
	localparam logic [5:0] K_STAR     = 6'd19;
	localparam logic [5:0] K_SLASH    = 6'd20;
	localparam logic [5:0] K_ASSIGN   = 6'd21;
	localparam logic [5:0] K_EQEQ     = 6'd22;
	localparam logic [5:0] K_NEQ      = 6'd23;
	localparam logic [5:0] K_GT       = 6'd24;
	localparam logic [5:0] K_LT       = 6'd25;
	localparam logic [5:0] K_GE       = 6'd26;
	localparam logic [5:0] K_LE       = 6'd27;
	localparam logic [5:0] K_LPAREN   = 6'd28;
	localparam logic [5:0] K_RPAREN   = 6'd29;
	localparam logic [5:0] K_LBRACE   = 6'd30;
	localparam logic [5:0] K_RBRACE   = 6'd31;
	localparam logic [5:0] K_COLON    = 6'd32;
	localparam logic [5:0] K_COMMA    = 6'd33;
	localparam logic [5:0] K_SEMI     = 6'd34;
	localparam logic [5:0] K_EOF      = 6'd35;
	localparam logic [5:0] K_ERROR    = 6'd36;

	localparam logic [2:0] E_NONE       = 3'd0;
	localparam logic [2:0] E_STR_NL     = 3'd1;
	localparam logic [2:0] E_STR_OPEN   = 3'd2;
	localparam logic [2:0] E_LONE_BANG  = 3'd3;
	localparam logic [2:0] E_UNEXPECTED = 3'd4;

	// keyword spelling, first character at index 0, padded with zero
	localparam logic [7:0] KW_CHAR [KW_COUNT][KW_MAX_CHARS] = '{
		'{"l", "e", "t", 8'h00, 8'h00, 8'h00},
		'{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"t", "r", "u", "e", 8'h00, 8'h00},
		'{"f", "a", "l", "s", "e", 8'h00},
		'{"v", "o", "i", "d", 8'h00, 8'h00},
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"f", "l", "o", "a", "t", 8'h00},
		'{"s", "t", "r", "i", "n", "g"},
		'{"b", "o", "o", "l", 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd3, 3'd2, 3'd6, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3, 3'd5, 3'd6, 3'd4
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [2:0]  err;
		logic [15:0] line;
		logic [15:0] col;
		logic [15:0] off;
		logic [15:0] len;
	} tok_t;

	// all tokens caused by one source byte
	typedef struct packed {
		logic [1:0]     n;
		tok_t [2:0]     tok;
	} bundle_t;

endpackage

// File: rtl/core/stu_front.sv
// Scanner front end: consumes one source byte per beat and forms its tokens.
`timescale 1ns / 1ps
module stu_front import stu_pkg::*; #(
	parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF,
	parameter int POSITION_BITS   = POSITION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] ch,
	output bundle_t    bundle
);
	localparam int P  = POSITION_BITS;
	localparam int IW = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_IDENT, M_NUMBER, M_NUMDOT, M_FRACTION,
		M_STRING, M_EQ, M_BANG, M_GT, M_LT
	} mode_t;

	typedef struct packed {
		mode_t        mode;
		logic [P-1:0] line;
		logic [P-1:0] col;
		logic [P-1:0] off;
		logic [P-1:0] tstart;
		logic [P-1:0] tlen;
		logic [P-1:0] scol;
	} st_t;

	localparam st_t ST_RESET = '{mode: M_IDLE, line: P'(1), col: P'(1), off: '0,
		tstart: '0, tlen: '0, scol: P'(1)};

	st_t st_q, nx;
	logic [MAX_KEYWORD_LEN-1:0][7:0] wbuf_q;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic          again, idle_pass;
	logic [1:0]    n;
	tok_t [2:0]    toks;
	logic          alpha, digit;

	function automatic logic [P-1:0] sat_add(input logic [P-1:0] a, input logic [1:0] b);
		logic [P:0] s;
		s = {1'b0, a} + {{(P-1){1'b0}}, b};
		return s[P] ? {P{1'b1}} : s[P-1:0];
	endfunction

	function automatic logic [P-1:0] sat_add_w(input logic [P-1:0] a, input logic [P-1:0] b);
		logic [P:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[P] ? {P{1'b1}} : s[P-1:0];
	endfunction

	function automatic tok_t mk(input logic [5:0] kind, input logic [2:0] err,
		input logic [P-1:0] line, input logic [P-1:0] col, input logic [P-1:0] off,
		input logic [P-1:0] len);
		tok_t t;
		t.kind = kind;
		t.err  = err;
		t.line = 16'(line);
		t.col  = 16'(col);
		t.off  = 16'(off);
		t.len  = 16'(len);
		return t;
	endfunction

	function automatic logic [5:0] word_kind(input logic [MAX_KEYWORD_LEN-1:0][7:0] w,
		input logic [P-1:0] tlen);
		logic [5:0] k;
		logic       hit;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			hit = (tlen == P'(KW_LEN[i]));
			for (int j = 0; j < KW_MAX_CHARS; j++) begin
				if (j < int'(KW_LEN[i]) && w[j] != KW_CHAR[i][j])
					hit = 1'b0;
			end
			if (hit)
				k = 6'(i);
		end
		return k;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		case (c)
			"+":     return K_PLUS;
			"-":     return K_MINUS;
			"*":     return K_STAR;
			"/":     return K_SLASH;
			"(":     return K_LPAREN;
			")":     return K_RPAREN;
			"{":     return K_LBRACE;
			"}":     return K_RBRACE;
			":":     return K_COLON;
			",":     return K_COMMA;
			";":     return K_SEMI;
			default: return K_ERROR;
		endcase
	endfunction

	assign alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
	assign digit = ch >= "0" && ch <= "9";

	always_comb begin
		nx        = st_q;
		n         = 2'd0;
		toks      = '0;
		again     = 1'b0;
		idle_pass = 1'b0;
		wr_en     = 1'b0;
		wr_idx    = '0;

		// first pass: finish or extend the token in flight
		case (st_q.mode)
			M_COMMENT: begin
				if (ch == "\n" || ch == 8'h00) begin
					nx.mode = M_IDLE;
					again   = 1'b1;
				end else begin
					nx.col = sat_add(nx.col, 2'd1);
					nx.off = sat_add(nx.off, 2'd1);
				end
			end
			M_IDENT: begin
				if (alpha || digit) begin
					if (st_q.tlen < P'(MAX_KEYWORD_LEN)) begin
						wr_en  = 1'b1;
						wr_idx = st_q.tlen[IW-1:0];
					end
					nx.tlen = sat_add(nx.tlen, 2'd1);
					nx.col  = sat_add(nx.col, 2'd1);
					nx.off  = sat_add(nx.off, 2'd1);
				end else begin
					toks[0] = mk(word_kind(wbuf_q, st_q.tlen), E_NONE, st_q.line,
						st_q.scol, st_q.tstart, st_q.tlen);
					n       = 2'd1;
					nx.mode = M_IDLE;
					again   = 1'b1;
				end
			end
			M_NUMBER, M_FRACTION: begin
				if (digit) begin
					nx.tlen = sat_add(nx.tlen, 2'd1);
					nx.col  = sat_add(nx.col, 2'd1);
					nx.off  = sat_add(nx.off, 2'd1);
				end else if (ch == "." && st_q.mode == M_NUMBER) begin
					nx.col  = sat_add(nx.col, 2'd1);
					nx.off  = sat_add(nx.off, 2'd1);
					nx.mode = M_NUMDOT;
				end else begin
					toks[0] = mk((st_q.mode == M_NUMBER) ? K_INTLIT : K_FLOATLIT, E_NONE,
						st_q.line, st_q.scol, st_q.tstart, st_q.tlen);
					n       = 2'd1;
					nx.mode = M_IDLE;
					again   = 1'b1;
				end
			end
			M_NUMDOT: begin
				if (digit) begin
					nx.tlen = sat_add(nx.tlen, 2'd2);
					nx.col  = sat_add(nx.col, 2'd1);
					nx.off  = sat_add(nx.off, 2'd1);
					nx.mode = M_FRACTION;
				end else begin
					// integer, then the dangling dot, just past the digits, as an
					// unexpected character
					toks[0] = mk(K_INTLIT, E_NONE, st_q.line, st_q.scol, st_q.tstart,
						st_q.tlen);
					toks[1] = mk(K_ERROR, E_UNEXPECTED, st_q.line, st_q.col,
						sat_add_w(st_q.tstart, st_q.tlen), '0);
					n       = 2'd2;
					nx.mode = M_IDLE;
					again   = 1'b1;
				end
			end
			M_STRING: begin
				if (ch == "\"") begin
					nx.tlen = sat_add(nx.tlen, 2'd1);
					nx.col  = sat_add(nx.col, 2'd1);
					nx.off  = sat_add(nx.off, 2'd1);
					toks[0] = mk(K_STRLIT, E_NONE, nx.line, nx.scol, nx.tstart, nx.tlen);
					n       = 2'd1;
					nx.mode = M_IDLE;
				end else if (ch == "\n" || ch == 8'h00) begin
					toks[0] = mk(K_ERROR, (ch == 8'h00) ? E_STR_OPEN : E_STR_NL,
						st_q.line, st_q.col, st_q.tstart, '0);
					n       = 2'd1;
					nx.mode = M_IDLE;
					again   = 1'b1;
				end else begin
					nx.tlen = sat_add(nx.tlen, 2'd1);
					nx.col  = sat_add(nx.col, 2'd1);
					nx.off  = sat_add(nx.off, 2'd1);
				end
			end
			M_EQ, M_GT, M_LT, M_BANG: begin
				if (ch == "=") begin
					nx.col  = sat_add(nx.col, 2'd1);
					nx.off  = sat_add(nx.off, 2'd1);
					nx.tlen = P'(2);
					toks[0] = mk((st_q.mode == M_EQ) ? K_EQEQ :
						(st_q.mode == M_GT) ? K_GE : (st_q.mode == M_LT) ? K_LE : K_NEQ,
						E_NONE, nx.line, nx.scol, nx.tstart, nx.tlen);
					n       = 2'd1;
					nx.mode = M_IDLE;
				end else begin
					if (st_q.mode == M_BANG)
						toks[0] = mk(K_ERROR, E_LONE_BANG, st_q.line, st_q.col,
							st_q.tstart, '0);
					else
						toks[0] = mk((st_q.mode == M_EQ) ? K_ASSIGN :
							(st_q.mode == M_GT) ? K_GT : K_LT, E_NONE, st_q.line,
							st_q.scol, st_q.tstart, st_q.tlen);
					n       = 2'd1;
					nx.mode = M_IDLE;
					again   = 1'b1;
				end
			end
			default: begin
				nx.mode   = M_IDLE;
				idle_pass = 1'b1;
			end
		endcase

		// second pass: the byte seen from the idle state
		if (idle_pass || again) begin
			if (ch == 8'h00) begin
				toks[n] = mk(K_EOF, E_NONE, nx.line, nx.col, nx.off, '0);
				n       = n + 2'd1;
				nx      = ST_RESET;
			end else if (ch == " " || ch == "\r" || ch == "\t") begin
				nx.col = sat_add(nx.col, 2'd1);
				nx.off = sat_add(nx.off, 2'd1);
			end else if (ch == "\n") begin
				nx.line = sat_add(nx.line, 2'd1);
				nx.col  = P'(1);
				nx.off  = sat_add(nx.off, 2'd1);
			end else if (ch == "#") begin
				nx.col  = sat_add(nx.col, 2'd1);
				nx.off  = sat_add(nx.off, 2'd1);
				nx.mode = M_COMMENT;
			end else begin
				nx.tstart = nx.off;
				nx.scol   = nx.col;
				nx.tlen   = P'(1);
				nx.col    = sat_add(nx.col, 2'd1);
				nx.off    = sat_add(nx.off, 2'd1);
				if (alpha) begin
					wr_en   = 1'b1;
					wr_idx  = '0;
					nx.mode = M_IDENT;
				end else if (digit)
					nx.mode = M_NUMBER;
				else if (ch == "\"")
					nx.mode = M_STRING;
				else if (ch == "=")
					nx.mode = M_EQ;
				else if (ch == "!")
					nx.mode = M_BANG;
				else if (ch == ">")
					nx.mode = M_GT;
				else if (ch == "<")
					nx.mode = M_LT;
				else begin
					nx.mode = M_IDLE;
					if (single_kind(ch) != K_ERROR)
						toks[n] = mk(single_kind(ch), E_NONE, nx.line, nx.scol,
							nx.tstart, nx.tlen);
					else
						toks[n] = mk(K_ERROR, E_UNEXPECTED, nx.line, nx.col,
							nx.tstart, '0);
					n = n + 2'd1;
				end
			end
		end

		bundle.n   = n;
		bundle.tok = toks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (accept) begin
			st_q <= nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en)
			wbuf_q[wr_idx] <= ch;
	end

endmodule

// File: rtl/core/stu_queue.sv
// Bundle queue between the scanner and the token serializer.
`timescale 1ns / 1ps
module stu_queue import stu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output logic    full,
	output logic    head_valid,
	output bundle_t head_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t       mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full       = cnt_q == CW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_data  = mem_q[rd_q];

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= nxt(wr_q);
			if (pop)
				rd_q <= nxt(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

// File: rtl/core/stu_back.sv
// Token serializer: hands out the tokens of each bundle one beat at a time.
`timescale 1ns / 1ps
module stu_back import stu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  bundle_t     head_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [2:0]  error_kind,
	output logic [15:0] line_no,
	output logic [15:0] column_no,
	output logic [15:0] start_offset,
	output logic [15:0] token_length,
	output logic        last_of_run
);
	logic [1:0] idx_q;
	tok_t       t;

	assign t            = head_data.tok[idx_q];
	assign out_valid    = head_valid;
	assign last_of_run  = idx_q == head_data.n - 2'd1;
	assign pop          = out_valid && out_ready && last_of_run;
	assign token_kind   = t.kind;
	assign error_kind   = t.err;
	assign line_no      = t.line;
	assign column_no    = t.col;
	assign start_offset = t.off;
	assign token_length = t.len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= last_of_run ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// File: rtl/core/source_tokenizer_unit.sv
// Top level of the source tokenizer: scanner, bundle queue and token serializer.
// The tokens a byte ends are registered in the bundle queue and offered from its head.
// Throughput: one source byte per cycle while the bundle queue has room; tokens leave at
// one per cycle while out_ready is high, so the tokens of one byte leave one after another.
// The queue depth (QUEUE_DEPTH bundles) sets how long a burst of tokens is absorbed.
// Reset (arst_n low, asynchronous) returns to line 1, column 1, offset 0, queue empty.
`timescale 1ns / 1ps
module source_tokenizer_unit import stu_pkg::*; #(
	parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF,
	parameter int POSITION_BITS   = POSITION_BITS_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [2:0]  error_kind,
	output logic [15:0] line_no,
	output logic [15:0] column_no,
	output logic [15:0] start_offset,
	output logic [15:0] token_length,
	output logic        last_of_run
);
	logic    accept, full, head_valid, pop;
	bundle_t bundle, head_data;

	// take a byte whenever the queue can hold whatever it produces
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	stu_front #(
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN),
		.POSITION_BITS  (POSITION_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.ch    (ch),
		.bundle(bundle)
	);

	// bytes that only advance position push nothing
	stu_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && bundle.n != 2'd0),
		.push_data (bundle),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	stu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.error_kind  (error_kind),
		.line_no     (line_no),
		.column_no   (column_no),
		.start_offset(start_offset),
		.token_length(token_length),
		.last_of_run (last_of_run)
	);

endmodule

// File: tb/source_tokenizer_unit_tb.sv
// Self-checking testbench for the source tokenizer: directed table, then random source text.
`timescale 1ns / 1ps
module source_tokenizer_unit_tb;
	import stu_pkg::*;

	// Scanner modes of the token predictor
	typedef enum int {SM_IDLE, SM_COMMENT, SM_WORD, SM_INT, SM_DOT, SM_FRAC,
		SM_STR, SM_EQ, SM_BANG, SM_GT, SM_LT} scan_e;

	typedef struct {
		tok_t t;
		bit   last;
	} token_beat_t;

	// One row of the directed table: a source byte, and optionally the kind and
	// error kind of the last token that byte must close.
	typedef struct {
		logic [7:0] c;
		bit         typed;
		logic [5:0] kind;
		logic [2:0] err;
	} row_t;

	localparam int unsigned POS_LIMIT = 65535;
	localparam logic [5:0] NO_KIND = 6'h3F;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  ch;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  token_kind;
	logic [2:0]  error_kind;
	logic [15:0] line_no;
	logic [15:0] column_no;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic        last_of_run;

	// Predictor state
	scan_e       mode;
	int unsigned line_cnt, col_cnt, byte_off, tok_start, tok_len, tok_col;
	logic [7:0]  word_chars [MAX_KEYWORD_LEN_DEF];
	token_beat_t pending [3];
	int          pending_n;

	token_beat_t expected_tokens [$];
	int          mismatches;
	int          bytes_sent;
	int          tokens_seen;
	bit          stimulus_done;

	source_tokenizer_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .ch(ch),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .error_kind(error_kind), .line_no(line_no),
		.column_no(column_no), .start_offset(start_offset),
		.token_length(token_length), .last_of_run(last_of_run)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ---------------- token predictor ----------------

	function automatic int unsigned sat(int unsigned a, int unsigned b);
		return (a + b > POS_LIMIT) ? POS_LIMIT : a + b;
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	task automatic reset_scanner();
		mode = SM_IDLE;
		line_cnt = 1;
		col_cnt = 1;
		byte_off = 0;
		tok_start = 0;
		tok_len = 0;
		tok_col = 1;
		foreach (word_chars[i]) word_chars[i] = 8'h00;
	endtask

	task automatic put(logic [5:0] kind, logic [2:0] err, int unsigned ln,
			int unsigned cl, int unsigned of, int unsigned len);
		if (pending_n < 3) begin
			pending[pending_n].t = '{kind: kind, err: err, line: ln[15:0], col: cl[15:0],
				off: of[15:0], len: len[15:0]};
			pending[pending_n].last = 1'b0;
			pending_n++;
		end
	endtask

	task automatic advance();
		col_cnt = sat(col_cnt, 1);
		byte_off = sat(byte_off, 1);
	endtask

	task automatic open_token(scan_e m);
		tok_start = byte_off;
		tok_col = col_cnt;
		tok_len = 1;
		mode = m;
		advance();
	endtask

	task automatic close_token(logic [5:0] kind);
		put(kind, E_NONE, line_cnt, tok_col, tok_start, tok_len);
		mode = SM_IDLE;
	endtask

	task automatic close_error(logic [2:0] err);
		put(K_ERROR, err, line_cnt, col_cnt, tok_start, 0);
		mode = SM_IDLE;
	endtask

	// keyword index, or identifier when nothing matches
	function automatic logic [5:0] classify_word();
		bit hit;
		if (tok_len > MAX_KEYWORD_LEN_DEF) return K_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			hit = (KW_LEN[k] == tok_len);
			for (int j = 0; j < KW_MAX_CHARS; j++)
				if (j < KW_LEN[k] && word_chars[j] != KW_CHAR[k][j]) hit = 1'b0;
			if (hit) return k[5:0];
		end
		return K_IDENT;
	endfunction

	function automatic logic [5:0] single_char_kind(logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			":": return K_COLON;
			",": return K_COMMA;
			";": return K_SEMI;
			default: return NO_KIND;
		endcase
	endfunction

	task automatic scan_from_idle(logic [7:0] c);
		logic [5:0] k;
		if (c == 8'h00) begin
			put(K_EOF, E_NONE, line_cnt, col_cnt, byte_off, 0);
			reset_scanner();
		end else if (c == " " || c == 8'h0D || c == 8'h09) begin
			advance();
		end else if (c == 8'h0A) begin
			line_cnt = sat(line_cnt, 1);
			col_cnt = 1;
			byte_off = sat(byte_off, 1);
		end else if (c == "#") begin
			advance();
			mode = SM_COMMENT;
		end else if (is_letter(c)) begin
			word_chars[0] = c;
			open_token(SM_WORD);
		end else if (is_num(c)) open_token(SM_INT);
		else if (c == "\"") open_token(SM_STR);
		else if (c == "=") open_token(SM_EQ);
		else if (c == "!") open_token(SM_BANG);
		else if (c == ">") open_token(SM_GT);
		else if (c == "<") open_token(SM_LT);
		else begin
			k = single_char_kind(c);
			open_token(SM_IDLE);
			if (k != NO_KIND) close_token(k);
			else close_error(E_UNEXPECTED);
		end
	endtask

	task automatic pair_or_single(logic [7:0] c, logic [5:0] one, logic [5:0] two,
			ref bit again);
		if (c == "=") begin
			advance();
			tok_len = 2;
			close_token(two);
		end else begin
			close_token(one);
			again = 1'b1;
		end
	endtask

	// Run one accepted byte through the predictor and queue the tokens it closes.
	task automatic predict_tokens(logic [7:0] c);
		bit again;
		again = 1'b1;
		pending_n = 0;
		for (int pass = 0; again && pass < 3; pass++) begin
			again = 1'b0;
			case (mode)
				SM_COMMENT: begin
					if (c == 8'h0A || c == 8'h00) begin
						mode = SM_IDLE;
						again = 1'b1;
					end else advance();
				end
				SM_WORD: begin
					if (is_letter(c) || is_num(c)) begin
						if (tok_len < MAX_KEYWORD_LEN_DEF) word_chars[tok_len] = c;
						tok_len = sat(tok_len, 1);
						advance();
					end else begin
						close_token(classify_word());
						again = 1'b1;
					end
				end
				SM_INT: begin
					if (is_num(c)) begin
						tok_len = sat(tok_len, 1);
						advance();
					end else if (c == ".") begin
						advance();
						mode = SM_DOT;
					end else begin
						close_token(K_INTLIT);
						again = 1'b1;
					end
				end
				SM_DOT: begin
					if (is_num(c)) begin
						tok_len = sat(tok_len, 2);
						advance();
						mode = SM_FRAC;
					end else begin
						// the dot after an integer stands alone as an unexpected char
						close_token(K_INTLIT);
						put(K_ERROR, E_UNEXPECTED, line_cnt, col_cnt, sat(tok_start, tok_len), 0);
						again = 1'b1;
					end
				end
				SM_FRAC: begin
					if (is_num(c)) begin
						tok_len = sat(tok_len, 1);
						advance();
					end else begin
						close_token(K_FLOATLIT);
						again = 1'b1;
					end
				end
				SM_STR: begin
					if (c == "\"") begin
						tok_len = sat(tok_len, 1);
						advance();
						close_token(K_STRLIT);
					end else if (c == 8'h0A) begin
						close_error(E_STR_NL);
						again = 1'b1;
					end else if (c == 8'h00) begin
						close_error(E_STR_OPEN);
						again = 1'b1;
					end else begin
						tok_len = sat(tok_len, 1);
						advance();
					end
				end
				SM_EQ: pair_or_single(c, K_ASSIGN, K_EQEQ, again);
				SM_GT: pair_or_single(c, K_GT, K_GE, again);
				SM_LT: pair_or_single(c, K_LT, K_LE, again);
				SM_BANG: begin
					if (c == "=") begin
						advance();
						tok_len = 2;
						close_token(K_NEQ);
					end else begin
						close_error(E_LONE_BANG);
						again = 1'b1;
					end
				end
				default: begin
					mode = SM_IDLE;
					scan_from_idle(c);
				end
			endcase
		end
		if (pending_n > 0) pending[pending_n - 1].last = 1'b1;
		for (int i = 0; i < pending_n; i++) expected_tokens.push_back(pending[i]);
	endtask

	// ---------------- source side ----------------

	// Offer one byte after a random gap; hold it until the handshake and predict.
	task automatic send_byte(logic [7:0] c);
		int gap;
		// every fourth block of 16 bytes runs back to back
		gap = ((bytes_sent / 16) % 4 == 1) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		do @(posedge clk); while (!in_ready);
		predict_tokens(c);
		bytes_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	function automatic string random_word(int n, bit digits_ok);
		string s;
		string alpha;
		alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, string'(alpha[$urandom_range(0, (digits_ok && i > 0) ? 62 : 52)])};
		return s;
	endfunction

	function automatic string random_digits(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	// Emit one well-formed or deliberately broken piece of source text.
	task automatic send_fragment();
		string kw [14];
		string ops [19];
		string seps [4];
		kw = '{"let", "fn", "return", "if", "else", "while", "true", "false", "void",
			"int", "float", "string", "bool", "returns"};
		ops = '{"+", "-", "*", "/", "=", "==", "!=", ">", "<", ">=", "<=", "(", ")",
			"{", "}", ":", ",", ";", "!"};
		seps = '{" ", "\t", "\r", ""};
		case ($urandom_range(0, 13))
			0, 1: send_text(kw[$urandom_range(0, 13)]);
			2: send_text(random_word($urandom_range(1, 9), 1'b1));
			3: send_text(random_digits($urandom_range(1, 4)));
			4: send_text({random_digits($urandom_range(1, 3)), ".",
				random_digits($urandom_range(1, 3))});
			5: send_text({"\"", random_word($urandom_range(0, 5), 1'b1), "\""});
			6, 7: send_text(ops[$urandom_range(0, 18)]);
			8: send_text("\n");
			9: send_text({"#", random_word($urandom_range(0, 4), 1'b0), "\n"});
			10: send_byte(8'($urandom_range(1, 255)));
			11: send_text({"\"", random_word($urandom_range(0, 3), 1'b0), "\n"});
			12: send_text({random_digits($urandom_range(1, 2)), ".",
				random_word(1, 1'b0)});
			default: if ($urandom_range(0, 3) == 0) send_byte(8'h00);
		endcase
		send_text(seps[$urandom_range(0, 3)]);
	endtask

	// ---------------- sink side ----------------

	// Draw a stall per token; once, hold off long enough to fill the queue.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (tokens_seen == 40) stall = 80;
			else if ((tokens_seen / 20) % 3 == 2) stall = 0;
			else stall = $urandom_range(0, 13);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			tokens_seen++;
		end
	end

	// Compare every token beat with the oldest expectation.
	always @(posedge clk) begin
		token_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token: kind %0d err %0d line %0d col %0d",
						token_kind, error_kind, line_no, column_no);
			end else begin
				want = expected_tokens.pop_front();
				if (token_kind !== want.t.kind || error_kind !== want.t.err ||
						line_no !== want.t.line || column_no !== want.t.col ||
						start_offset !== want.t.off || token_length !== want.t.len ||
						last_of_run !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("token mismatch: expected kind %0d err %0d line %0d col %0d off %0d len %0d last %0d",
							want.t.kind, want.t.err, want.t.line, want.t.col, want.t.off,
							want.t.len, want.last);
						$display("                actual   kind %0d err %0d line %0d col %0d off %0d len %0d last %0d",
							token_kind, error_kind, line_no, column_no, start_offset,
							token_length, last_of_run);
					end
				end
			end
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		row_t table_rows [$];
		int waited;
		table_rows = '{
			'{"l", 0, 0, 0}, '{"e", 0, 0, 0}, '{"t", 0, 0, 0}, '{" ", 1, 6'd0, E_NONE},
			'{"x", 0, 0, 0}, '{"=", 1, K_IDENT, E_NONE}, '{"=", 1, K_EQEQ, E_NONE},
			'{"1", 0, 0, 0}, '{"2", 0, 0, 0}, '{".", 0, 0, 0}, '{"5", 0, 0, 0},
			'{";", 1, K_SEMI, E_NONE},
			'{"9", 0, 0, 0}, '{".", 0, 0, 0}, '{"x", 1, K_ERROR, E_UNEXPECTED},
			'{"!", 0, 0, 0}, '{"a", 1, K_ERROR, E_LONE_BANG},
			'{"\"", 0, 0, 0}, '{"h", 0, 0, 0}, '{8'h0A, 1, K_ERROR, E_STR_NL},
			'{"#", 0, 0, 0}, '{"c", 0, 0, 0}, '{8'h0A, 0, 0, 0},
			'{8'hFF, 1, K_ERROR, E_UNEXPECTED}, '{8'h80, 1, K_ERROR, E_UNEXPECTED},
			'{">", 0, 0, 0}, '{"=", 1, K_GE, E_NONE},
			'{"<", 0, 0, 0}, '{"(", 1, K_LPAREN, E_NONE},
			'{"\"", 0, 0, 0}, '{"q", 0, 0, 0}, '{8'h00, 1, K_EOF, E_NONE}
		};
		mismatches = 0;
		bytes_sent = 0;
		tokens_seen = 0;
		stimulus_done = 1'b0;
		reset_scanner();
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed rows pin the kind and error kind of the last token they close
		foreach (table_rows[i]) begin
			send_byte(table_rows[i].c);
			if (table_rows[i].typed) begin
				expected_tokens[$].t.kind = table_rows[i].kind;
				expected_tokens[$].t.err = table_rows[i].err;
			end
		end

		// random source text, closed by an end byte
		while (bytes_sent < 130) send_fragment();
		send_byte(8'h00);
		in_valid <= 1'b0;
		stimulus_done = 1'b1;

		waited = 0;
		while (expected_tokens.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/stu_pkg.sv
rtl/core/stu_front.sv
rtl/core/stu_queue.sv
rtl/core/stu_back.sv
rtl/core/source_tokenizer_unit.sv
tb/source_tokenizer_unit_tb.sv
